### sv/srs_pkg.sv
package srs_pkg;

  // item kind carried on the input tuser
  localparam logic KIND_CALL   = 1'b0;
  localparam logic KIND_RETURN = 1'b1;

  // field widths
  localparam int unsigned PtrW  = 64;
  localparam int unsigned AddrW = 64;
  localparam int unsigned SlotW = 5;

  localparam logic [SlotW-1:0] SlotReset = 5'd8;

  // result codes
  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_SUCCESS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

endpackage

### sv/shadow_return_stack_checker.sv
// Shadow return stack checker.
// Input beats on s_axis: tuser is the kind (call or return), tdata carries the
// stack pointer and the address (return address for a call, actual target
// for a return). Each input beat gives exactly one result beat on m_axis:
// tdata holds the status code and the longjmp flag.
// For a call, the entry is written to the stack memory at the accept edge
// unless the stack is full, and the result is registered at that edge too.
// A return walks the stack down from the top, unwinding stale entries: each
// walk step is one read of the stack memory and one compare of its registered
// read data. A new beat is taken as soon as the walk is over, even while the
// last result still waits in the output register.
// If the receiver stalls while a second result is ready, that result waits in
// a holding register and no further beat is taken until it moves on.
// Reset clears the stack depth, the output valid and sets the slot size to 8;
// the stack memory itself is not cleared, only entries below the depth are read.
// the user writes slot size (cfg_we_i / cfg_wdata_i) only while idle; unenforced.
module shadow_return_stack_checker
  import srs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: slot size in bytes
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] stack_pointer, [127:64] address
  input  logic         s_axis_tuser,   // [0] kind
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata    // [2:0] status, [3] longjmp_seen, [7:4] zero
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SlotW-1:0]  slot_q;
  logic [PtrW-1:0]   sp_q, sp_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              lj_q, lj_d;
  status_e           pend_status_q, pend_status_d;
  logic              pend_lj_q, pend_lj_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic              out_lj_q, out_lj_d;

  // stack memory
  logic [PtrW-1:0]   mem_ptr [STACK_DEPTH];
  logic [AddrW-1:0]  mem_ra  [STACK_DEPTH];
  logic [PtrW-1:0]   rd_ptr_q;
  logic [AddrW-1:0]  rd_ra_q;
  logic              mem_we;
  logic [AW-1:0]     wr_idx;
  logic [PtrW-1:0]   wr_ptr;
  logic              rd_en;
  logic [AW-1:0]     rd_idx;

  logic              s_fire, m_fire, can_out, full;
  logic [CW-1:0]     count_m1, count_m2;
  logic              fin;
  status_e           fin_status;
  logic              fin_lj;
  logic [PtrW-1:0]   in_sp;
  logic [AddrW-1:0]  in_addr;
  logic              in_kind;

  assign in_sp   = s_axis_tdata[63:0];
  assign in_addr = s_axis_tdata[127:64];
  assign in_kind = s_axis_tuser;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = out_valid_q && m_axis_tready;
  assign can_out  = !out_valid_q || m_axis_tready;
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign count_m1 = count_q - CW'(1);
  assign count_m2 = count_q - CW'(2);
  assign wr_idx   = count_q[AW-1:0];
  assign wr_ptr   = in_sp - {{(PtrW-SlotW){1'b0}}, slot_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_lj_q, out_status_q};

  // walk control and result routing
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    sp_d          = sp_q;
    addr_d        = addr_q;
    lj_d          = lj_q;
    pend_status_d = pend_status_q;
    pend_lj_d     = pend_lj_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_lj_d      = out_lj_q;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = count_m1[AW-1:0];
    fin           = 1'b0;
    fin_status    = ST_PUSHED;
    fin_lj        = 1'b0;

    if (m_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (in_kind == KIND_CALL) begin
            fin = 1'b1;
            if (full) begin
              fin_status = ST_OVERFLOW;
            end else begin
              mem_we     = 1'b1;
              count_d    = count_q + CW'(1);
              fin_status = ST_PUSHED;
            end
          end else begin
            sp_d   = in_sp;
            addr_d = in_addr;
            lj_d   = 1'b0;
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              rd_en   = 1'b1;
              rd_idx  = count_m1[AW-1:0];
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (rd_ptr_q > sp_q) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
          fin_lj     = lj_q;
        end else if (rd_ptr_q == sp_q) begin
          fin    = 1'b1;
          fin_lj = lj_q;
          if (rd_ra_q == addr_q) begin
            count_d    = count_m1;
            fin_status = ST_SUCCESS;
          end else begin
            fin_status = ST_MISMATCH;
          end
        end else begin
          // stale entry: drop it and look at the one below
          count_d = count_m1;
          lj_d    = 1'b1;
          if (count_q == CW'(1)) begin
            fin        = 1'b1;
            fin_status = ST_EMPTY;
            fin_lj     = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_idx = count_m2[AW-1:0];
          end
        end
      end
      S_HOLD: begin
        if (can_out) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_lj_d     = pend_lj_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // finished result goes to the output register or waits in the holding one
    if (fin) begin
      if (can_out) begin
        out_valid_d  = 1'b1;
        out_status_d = fin_status;
        out_lj_d     = fin_lj;
        state_d      = S_IDLE;
      end else begin
        pend_status_d = fin_status;
        pend_lj_d     = fin_lj;
        state_d       = S_HOLD;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      slot_q      <= SlotReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slot_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sp_q          <= sp_d;
    addr_q        <= addr_d;
    lj_q          <= lj_d;
    pend_status_q <= pend_status_d;
    pend_lj_q     <= pend_lj_d;
    out_status_q  <= out_status_d;
    out_lj_q      <= out_lj_d;
  end

  // stack memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_ptr[wr_idx] <= wr_ptr;
      mem_ra[wr_idx]  <= in_addr;
    end
    if (rd_en) begin
      rd_ptr_q <= mem_ptr[rd_idx];
      rd_ra_q  <= mem_ra[rd_idx];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind == KIND_CALL && !full) |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the stack");

  a_walk_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> count_q != '0)
    else $error("walk step on an empty stack");

  a_call_no_lj : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_PUSHED || out_status_q == ST_OVERFLOW))
      |-> !out_lj_q)
    else $error("longjmp flag on a call result");
`endif

endmodule
